/* rtl/pn9d_pkg.sv */
package pn9d_pkg;

    localparam int unsigned FRAME_SCRAMBLE_LEN = 182;
    localparam int unsigned POS_W = 8;
    localparam int unsigned PN_W = 9;
    localparam int unsigned SEED_W = 16;
    localparam int unsigned DIBIT_W = 2;
    localparam int unsigned TDATA_W = 8;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_SCRAMBLE_LEN);
    localparam logic [PN_W-1:0] PN_DEFAULT_SEED = PN_W'(228);
    localparam logic [PN_W-1:0] PN_MAX_SEED = {PN_W{1'b1}};
    localparam logic [DIBIT_W-1:0] SIGN_MASK = DIBIT_W'(2);

    typedef struct packed {
        logic step;
        logic last;
    } pn9d_step_t;

    function automatic logic [PN_W-1:0] seed_normalize(input logic [SEED_W-1:0] raw);
        logic [PN_W-1:0] res;
        if (raw == '0)
        begin
            res = PN_DEFAULT_SEED;
        end
        else if (raw[SEED_W-1:PN_W] != '0)
        begin
            res = PN_MAX_SEED;
        end
        else
        begin
            res = raw[PN_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/pn9d_seq.sv */
module pn9d_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             seed_we,
    input  logic [pn9d_pkg::SEED_W-1:0]      seed_data,
    input  pn9d_pkg::pn9d_step_t             ctrl,
    output logic                             flip
);

    logic [pn9d_pkg::SEED_W-1:0] seed_reg;
    logic [pn9d_pkg::POS_W-1:0]  pos_reg;
    logic [pn9d_pkg::POS_W-1:0]  pos_next;
    logic [pn9d_pkg::PN_W-1:0]   pn_reg;
    logic [pn9d_pkg::PN_W-1:0]   pn_next;
    logic [pn9d_pkg::PN_W-1:0]   pn_cur;
    logic                        active;

    always_comb
    begin
        pn_cur = (pos_reg == '0) ? pn9d_pkg::seed_normalize(seed_reg) : pn_reg;
        active = (pos_reg < pn9d_pkg::POS_LIMIT);
        flip = active & pn_cur[0];
        pn_next = pn_reg;
        pos_next = pos_reg;
        if (ctrl.step)
        begin
            pn_next = pn_cur;
            if (active)
            begin
                pn_next = {pn_cur[0] ^ pn_cur[4], pn_cur[pn9d_pkg::PN_W-1:1]};
                pos_next = pos_reg + 1'b1;
            end
            if (ctrl.last)
            begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            pos_reg <= '0;
            pn_reg <= pn9d_pkg::PN_DEFAULT_SEED;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_data;
            end
            pos_reg <= pos_next;
            pn_reg <= pn_next;
        end
    end

endmodule

/* rtl/pn9_dibit_descrambler.sv */
// PN9 dibit descrambler.
// Slave stream: one received dibit per transaction in s_axis_tdata[1:0],
// frame end on s_axis_tlast. Master stream: the descrambled dibit in
// m_axis_tdata[1:0] with its tlast copied through.
// Configuration: cfg_valid/cfg_data write the 16-bit scramble seed; cfg_ready
// is always high. Write only while the block is empty; the new seed is used
// from the next frame start.
// Path: input register, then result register. Throughput: one dibit per
// cycle while m_axis_tready is high, set by the one-step LFSR update between
// the two registers.
// Stall: when m_axis_tready is low the result holds, the input register
// still fills once, then s_axis_tready drops until the result is taken.
// Reset: both stages empty, seed 0 (used as 228), frame position 0.
module pn9_dibit_descrambler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pn9d_pkg::TDATA_W-1:0]       s_axis_tdata,   // [1:0] rx_dibit
    input  logic                               s_axis_tlast,   // frame_last
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pn9d_pkg::TDATA_W-1:0]       m_axis_tdata,   // [1:0] out_dibit
    output logic                               m_axis_tlast,   // out_last
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pn9d_pkg::SEED_W-1:0]        cfg_data
);

    logic                             in_valid_reg;
    logic [pn9d_pkg::DIBIT_W-1:0]     in_dibit_reg;
    logic                             in_last_reg;
    logic                             out_valid_reg;
    logic [pn9d_pkg::DIBIT_W-1:0]     out_dibit_reg;
    logic [pn9d_pkg::DIBIT_W-1:0]     out_dibit_next;
    logic                             out_last_reg;
    logic                             out_free;
    logic                             advance;
    logic                             flip;
    pn9d_pkg::pn9d_step_t             seq_ctrl;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign advance = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign seq_ctrl.step = advance;
    assign seq_ctrl.last = in_last_reg;

    pn9d_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed_we   (cfg_valid),
        .seed_data (cfg_data),
        .ctrl      (seq_ctrl),
        .flip      (flip)
    );

    assign out_dibit_next = flip ? (in_dibit_reg ^ pn9d_pkg::SIGN_MASK) : in_dibit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_dibit_reg <= s_axis_tdata[pn9d_pkg::DIBIT_W-1:0];
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_dibit_reg <= out_dibit_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {{(pn9d_pkg::TDATA_W - pn9d_pkg::DIBIT_W){1'b0}}, out_dibit_reg};
    assign m_axis_tlast = out_last_reg;

endmodule

/* rtl/pn9d_checker.sv */
module pn9d_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [pn9d_pkg::TDATA_W-1:0]       s_axis_tdata,
    input logic                               s_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pn9d_pkg::TDATA_W-1:0]       m_axis_tdata,
    input logic                               m_axis_tlast,
    input logic                               cfg_valid,
    input logic                               cfg_ready
);

    // Hold a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("seed write refused");

    // Pass the low bit and tlast through the input and result registers when the output is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=>
            m_axis_tvalid && (m_axis_tdata[0] == $past(s_axis_tdata[0], 2))
            && (m_axis_tlast == $past(s_axis_tlast, 2))
            && (m_axis_tdata[pn9d_pkg::TDATA_W-1:pn9d_pkg::DIBIT_W] == '0))
        else $error("result does not match accepted item");

endmodule

bind pn9_dibit_descrambler pn9d_checker u_pn9d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);
